// ===== hdl/pwcm_pkg.sv =====
// Package for the pose window circular mean unit.
// Holds sizes, the CORDIC arctangent table and the sequencer state type.
package pwcm_pkg;

  localparam int WINDOW_MAX   = 32;
  localparam int PTR_W        = $clog2(WINDOW_MAX);
  localparam int CNT_W        = 6;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_N       = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int STEP_W       = 5;
  // Fixed-point widths of the CORDIC datapath and the accumulators
  localparam int SW           = 37;
  localparam int PW           = 40;
  localparam int UNIT_SCALE   = 16777216;
  localparam logic [5:0] WINDOW_RESET = 6'd20;

  localparam logic REQ_PUSH    = 1'b0;
  localparam logic REQ_CAPTURE = 1'b1;
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_POSE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_SINCOS, S_ACCUM, S_VEC, S_DIV, S_OUT
  } seq_state_e;

  function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/pwcm_if.sv =====
// Channel interfaces for the pose window circular mean unit.
// Depends on nothing; payload widths follow the field list.
interface pwcm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] pose_x;
  logic [31:0] pose_y;
  logic [15:0] pose_yaw;
  modport source (output valid, req_type, pose_x, pose_y, pose_yaw, input ready);
  modport sink   (input valid, req_type, pose_x, pose_y, pose_yaw, output ready);
endinterface

interface pwcm_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] mean_x;
  logic [31:0] mean_y;
  logic [15:0] mean_yaw;
  logic [5:0]  samples_used;
  modport source (output valid, status, mean_x, mean_y, mean_yaw, samples_used,
                  input ready);
  modport sink   (input valid, status, mean_x, mean_y, mean_yaw, samples_used,
                  output ready);
endinterface

interface pwcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/pose_window_circular_mean_unit.sv =====
// Top level of the pose window circular mean unit.
// Depends on pwcm_pkg, the channel interfaces and pwcm_cordic.
//
// Usage: req carries push and capture requests, res returns one result per
// capture, cfg writes window_size (reset value 20; 0 acts as 1, above 32
// acts as 32). A push is taken and written into the pose ring. A capture
// walks the stored poses newest first: per pose a ring read, a CORDIC load,
// the rotation steps and an accumulate, then vectoring steps for atan2 and
// a restoring divider for both means. The single shared CORDIC stage serves
// rotation and vectoring; the divider gives one quotient bit per cycle. A
// capture with no pose goes straight to output with status no_pose. The
// result is held in an output register until the receiver takes it;
// req.ready stays low until then. Reset clears pointer, fill count and pose
// flag; ring contents are undefined until written.
module pose_window_circular_mean_unit
  import pwcm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pwcm_req_if.sink     req,
  pwcm_res_if.source   res,
  pwcm_cfg_if.sink     cfg
);
  seq_state_e state_q, state_d;
  logic [5:0]       win_q;
  logic [PTR_W-1:0] wp_q, rd_idx_q;
  logic [CNT_W-1:0] fill_q, k_q, n_q;
  logic             seen_q;
  logic [31:0] mem_x [WINDOW_MAX];
  logic [31:0] mem_y [WINDOW_MAX];
  logic [15:0] mem_yaw [WINDOW_MAX];
  logic [31:0] rx_q, ry_q;
  logic [15:0] ryaw_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic signed [PW-1:0] sc_q, ss_q;
  logic res_valid_q, status_q;
  logic [31:0] mx_q, my_q;
  logic [15:0] myaw_q;
  logic [5:0]  used_q;
  // divider
  logic [SW-1:0] qx_q, qy_q, rmx_q, rmy_q;
  logic [5:0]    dcnt_q;
  logic          negx_q, negy_q;

  logic [5:0] eff_win;
  logic push_go, cap_go;
  logic c_load, c_step, c_vec, c_done;
  logic signed [PW-1:0] c_xi, c_yi, c_xo, c_yo;
  logic signed [32:0] c_zi, c_zo;

  assign eff_win = (win_q == 6'd0) ? 6'd1 :
                   (win_q > 6'(WINDOW_MAX)) ? 6'(WINDOW_MAX) : win_q;
  assign req.ready = (state_q == S_IDLE) && !res_valid_q;
  assign cfg.ready = 1'b1;
  assign push_go = req.valid && req.ready && (req.req_type == REQ_PUSH);
  assign cap_go  = req.valid && req.ready && (req.req_type == REQ_CAPTURE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cap_go) state_d = (seen_q && fill_q != '0) ? S_READ : S_OUT;
      S_READ:   state_d = S_LOAD;
      S_LOAD:   state_d = S_SINCOS;
      S_SINCOS: if (c_done) state_d = S_ACCUM;
      S_ACCUM:  state_d = (k_q == n_q) ? S_VEC : S_READ;
      S_VEC:    if (c_done) state_d = S_DIV;
      S_DIV:    if (dcnt_q == 6'(SW)) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // CORDIC controls; the ring word is valid in S_LOAD
  always_comb begin
    logic signed [16:0] yw;
    logic flip;
    yw   = $signed({ryaw_q[15], ryaw_q});
    flip = (yw > 17'sd16384) || (yw < -17'sd16384);
    c_load = 1'b0;
    c_step = 1'b0;
    c_vec  = (state_q == S_VEC);
    c_xi   = flip ? -PW'(UNIT_SCALE) : PW'(UNIT_SCALE);
    c_yi   = '0;
    c_zi   = flip ? {(yw > 0 ? yw - 17'sd32768 : yw + 17'sd32768), 16'd0}
                  : {yw, 16'd0};
    if (state_q == S_LOAD) c_load = 1'b1;
    if (state_q == S_SINCOS && !c_done) c_step = 1'b1;
    if (state_q == S_VEC && !c_done) c_step = 1'b1;
    if (state_q == S_ACCUM && k_q == n_q) begin
      c_load = 1'b1;
      c_xi = (sc_q + c_xo < 0) ? -(sc_q + c_xo) : sc_q + c_xo;
      c_yi = (sc_q + c_xo < 0) ? -(ss_q + c_yo) : ss_q + c_yo;
      c_zi = (sc_q + c_xo < 0) ? 33'sh080000000 : '0;
    end
  end

  pwcm_cordic u_cordic (
    .clk_i, .load_i(c_load), .step_i(c_step), .vec_i(c_vec),
    .x_i(c_xi), .y_i(c_yi), .z_i(c_zi),
    .x_o(c_xo), .y_o(c_yo), .z_o(c_zo), .done_o(c_done)
  );

  // ring memory
  always_ff @(posedge clk_i) begin
    if (push_go) begin
      mem_x[wp_q]   <= req.pose_x;
      mem_y[wp_q]   <= req.pose_y;
      mem_yaw[wp_q] <= req.pose_yaw;
    end
    rx_q   <= mem_x[rd_idx_q];
    ry_q   <= mem_y[rd_idx_q];
    ryaw_q <= mem_yaw[rd_idx_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      win_q <= WINDOW_RESET;
      wp_q <= '0;
      fill_q <= '0;
      seen_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.valid && cfg.ready) win_q <= cfg.data;
      if (push_go) begin
        wp_q <= wp_q + 1'b1;
        if (fill_q < eff_win) fill_q <= fill_q + 1'b1;
        seen_q <= 1'b1;
      end
      if (state_q == S_OUT) res_valid_q <= 1'b1;
      else if (res.ready) res_valid_q <= 1'b0;
    end
  end

  // datapath: accumulate, divide, result
  always_ff @(posedge clk_i) begin
    logic [SW-1:0] ax, ay, tx, ty;
    ax = '0; ay = '0; tx = '0; ty = '0;
    if (cap_go) begin
      k_q <= '0;
      n_q <= fill_q;
      rd_idx_q <= wp_q - 1'b1;
      sx_q <= '0; sy_q <= '0; sc_q <= '0; ss_q <= '0;
    end
    if (state_q == S_READ) k_q <= k_q + 1'b1;
    if (state_q == S_ACCUM) begin
      rd_idx_q <= rd_idx_q - 1'b1;
      sx_q <= sx_q + SW'($signed(rx_q));
      sy_q <= sy_q + SW'($signed(ry_q));
      sc_q <= sc_q + c_xo;
      ss_q <= ss_q + c_yo;
    end
    if (state_q == S_VEC && c_done) begin
      ax = sx_q[SW-1] ? -sx_q : sx_q;
      ay = sy_q[SW-1] ? -sy_q : sy_q;
      negx_q <= sx_q[SW-1]; negy_q <= sy_q[SW-1];
      qx_q <= ax; qy_q <= ay; rmx_q <= '0; rmy_q <= '0; dcnt_q <= '0;
      myaw_q <= (sc_q == 0 && ss_q == 0) ? 16'd0 : 16'((c_zo[31:0] + 32'h8000) >> 16);
    end
    // restoring divide, one quotient bit per cycle for both means
    if (state_q == S_DIV && dcnt_q != 6'(SW)) begin
      tx = {rmx_q[SW-2:0], qx_q[SW-1]};
      ty = {rmy_q[SW-2:0], qy_q[SW-1]};
      if (tx >= SW'(n_q)) begin rmx_q <= tx - SW'(n_q); qx_q <= {qx_q[SW-2:0], 1'b1}; end
      else begin rmx_q <= tx; qx_q <= {qx_q[SW-2:0], 1'b0}; end
      if (ty >= SW'(n_q)) begin rmy_q <= ty - SW'(n_q); qy_q <= {qy_q[SW-2:0], 1'b1}; end
      else begin rmy_q <= ty; qy_q <= {qy_q[SW-2:0], 1'b0}; end
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (state_q == S_OUT) begin
      if (seen_q && n_q != '0) begin
        status_q <= ST_OK;
        mx_q <= negx_q ? 32'(-qx_q) : qx_q[31:0];
        my_q <= negy_q ? 32'(-qy_q) : qy_q[31:0];
        used_q <= n_q;
      end else begin
        status_q <= ST_NO_POSE;
        mx_q <= '0; my_q <= '0; myaw_q <= '0; used_q <= '0;
      end
    end
  end

  assign res.valid        = res_valid_q;
  assign res.status       = status_q;
  assign res.mean_x       = mx_q;
  assign res.mean_y       = my_q;
  assign res.mean_yaw     = myaw_q;
  assign res.samples_used = used_q;

  a_fill_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW_MAX)) else $error("fill count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
  a_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> res.valid) else $error("result lost");
endmodule

// ===== hdl/pwcm_cordic.sv =====
// Shared CORDIC stage: one micro-rotation per cycle while step_i is high, rotation or vectoring.
// Depends on pwcm_pkg.
module pwcm_cordic
  import pwcm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 step_i,
  input  logic                 vec_i,
  input  logic signed [PW-1:0] x_i,
  input  logic signed [PW-1:0] y_i,
  input  logic signed [32:0]   z_i,
  output logic signed [PW-1:0] x_o,
  output logic signed [PW-1:0] y_o,
  output logic signed [32:0]   z_o,
  output logic                 done_o
);
  logic signed [PW-1:0] x_q, x_d, y_q, y_d;
  logic signed [32:0]   z_q, z_d;
  logic [STEP_W-1:0]    i_q, i_d;
  logic                 up;
  logic signed [PW-1:0] dx, dy;
  logic signed [32:0]   a;

  // one rotation step; >>> is the floor shift
  always_comb begin
    dx  = y_q >>> i_q;
    dy  = x_q >>> i_q;
    a   = $signed({1'b0, atan_turns(i_q)});
    up  = vec_i ? (y_q <= 0) : (z_q >= 0);
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    if (load_i) begin
      x_d = x_i; y_d = y_i; z_d = z_i; i_d = '0;
    end else if (step_i) begin
      i_d = i_q + 1'b1;
      if (vec_i) begin
        if (!up) begin x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + a; end
        else     begin x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - a; end
      end else begin
        if (up)  begin x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - a; end
        else     begin x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + a; end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; i_q <= i_d;
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign done_o = (i_q == STEP_W'(STEP_N));
endmodule

// ===== tb/pose_window_scoreboard.sv =====
// Scoreboard for the pose window circular mean unit testbench.
// Depends on pwcm_pkg; holds the pose ring model and the expected result queue.
`timescale 1ns / 100ps

class pose_window_scoreboard;
  typedef struct packed {
    logic        status;
    logic [31:0] mean_x;
    logic [31:0] mean_y;
    logic [15:0] mean_yaw;
    logic [5:0]  samples_used;
  } mean_pose_t;

  logic signed [31:0] ring_x [pwcm_pkg::WINDOW_MAX];
  logic signed [31:0] ring_y [pwcm_pkg::WINDOW_MAX];
  logic signed [15:0] ring_yaw [pwcm_pkg::WINDOW_MAX];
  int unsigned wr_ptr;
  int unsigned fill;
  bit          seen;
  logic [5:0]  window;
  mean_pose_t  pending[$];
  int          errors;
  int          captures;
  int          pushes;

  function new();
    wr_ptr = 0;
    fill = 0;
    seen = 0;
    window = pwcm_pkg::WINDOW_RESET;
    errors = 0;
    captures = 0;
    pushes = 0;
  endfunction

  function void set_window(logic [5:0] w);
    window = w;
  endfunction

  // Floor shift of a signed value
  function longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function void rotate(logic signed [15:0] yaw, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = pwcm_pkg::UNIT_SCALE;
    y = 0;
    z = longint'(yaw) * 65536;
    if (yaw > 16384) begin
      x = -x;
      z = (longint'(yaw) - 32768) * 65536;
    end else if (yaw < -16384) begin
      x = -x;
      z = (longint'(yaw) + 32768) * 65536;
    end
    for (int i = 0; i < pwcm_pkg::STEP_N; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(pwcm_pkg::atan_turns(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(pwcm_pkg::atan_turns(5'(i)));
      end
    end
    c = x;
    s = y;
  endfunction

  function logic [31:0] vector_angle(longint sy, longint sx);
    longint x, y, z, dx, dy;
    x = sx; y = sy; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < pwcm_pkg::STEP_N; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(pwcm_pkg::atan_turns(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(pwcm_pkg::atan_turns(5'(i)));
      end
    end
    return z[31:0];
  endfunction

  // Note an accepted request transfer
  function void note_request(logic rtype, logic [31:0] px, logic [31:0] py,
                             logic [15:0] pyaw);
    int unsigned w, n, idx;
    longint sx, sy, sc, ss, c, s;
    logic [31:0] ang;
    mean_pose_t r;
    w = window;
    if (w < 1) w = 1;
    if (w > pwcm_pkg::WINDOW_MAX) w = pwcm_pkg::WINDOW_MAX;
    if (rtype == pwcm_pkg::REQ_PUSH) begin
      ring_x[wr_ptr] = px;
      ring_y[wr_ptr] = py;
      ring_yaw[wr_ptr] = pyaw;
      wr_ptr = (wr_ptr + 1) % pwcm_pkg::WINDOW_MAX;
      if (fill < w) fill++;
      seen = 1;
      pushes++;
      return;
    end
    captures++;
    n = fill;
    r = '0;
    if (!seen || n == 0) begin
      r.status = pwcm_pkg::ST_NO_POSE;
      pending.insert(pending.size(), r);
      return;
    end
    sx = 0; sy = 0; sc = 0; ss = 0;
    for (int k = 0; k < n; k++) begin
      idx = (wr_ptr + pwcm_pkg::WINDOW_MAX - 1 - k) % pwcm_pkg::WINDOW_MAX;
      sx += longint'(ring_x[idx]);
      sy += longint'(ring_y[idx]);
      rotate(ring_yaw[idx], c, s);
      sc += c;
      ss += s;
    end
    ang = (sc == 0 && ss == 0) ? 32'd0 : vector_angle(ss, sc);
    r.status = pwcm_pkg::ST_OK;
    r.mean_x = 32'(sx / longint'(n));
    r.mean_y = 32'(sy / longint'(n));
    r.mean_yaw = 16'((ang + 32'h8000) >> 16);
    r.samples_used = 6'(n);
    pending.insert(pending.size(), r);
  endfunction

  // Check an accepted result transfer against the oldest expectation
  function void check_result(mean_pose_t got);
    mean_pose_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending[0];
    pending.delete(0);
    if (got.status !== exp_r.status)
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
    if (got.mean_x !== exp_r.mean_x)
      $display("%0t: mean_x expected %h actual %h", $time, exp_r.mean_x, got.mean_x);
    if (got.mean_y !== exp_r.mean_y)
      $display("%0t: mean_y expected %h actual %h", $time, exp_r.mean_y, got.mean_y);
    if (got.mean_yaw !== exp_r.mean_yaw)
      $display("%0t: mean_yaw expected %h actual %h", $time, exp_r.mean_yaw,
               got.mean_yaw);
    if (got.samples_used !== exp_r.samples_used)
      $display("%0t: samples_used expected %0d actual %0d", $time,
               exp_r.samples_used, got.samples_used);
    if (got !== exp_r) errors++;
  endfunction
endclass

// ===== tb/testbench.sv =====
// Top testbench for pose_window_circular_mean_unit.
// Depends on pwcm_pkg, the channel interfaces and pose_window_scoreboard.
`timescale 1ns / 100ps

module testbench;
  import pwcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pwcm_req_if req();
  pwcm_res_if res();
  pwcm_cfg_if cfg();

  pose_window_circular_mean_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .res    (res.source),
    .cfg    (cfg.sink)
  );

  pose_window_scoreboard board = new();
  bit   calm;
  int   idle_cycles;
  int   sent;

  always #10 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_PUSH;
    req.pose_x = '0;
    req.pose_y = '0;
    req.pose_yaw = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
  end

  // Result sink with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready)
        board.check_result({res.status, res.mean_x, res.mean_y, res.mean_yaw,
                            res.samples_used});
    end
  end

  initial begin : sink_ready
    int k;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        res.ready <= 1'b0;
        k = $urandom_range(1, 7);
        repeat (k) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      k = $urandom_range(1, 10);
      repeat (k) @(posedge clk_i);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high after a transfer; a gap, a window write or the end drops it
  task automatic send_request(logic rtype, logic [31:0] px, logic [31:0] py,
                              logic [15:0] pyaw);
    int k;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      k = $urandom_range(1, 7);
      repeat (k) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= rtype;
    req.pose_x <= px;
    req.pose_y <= py;
    req.pose_yaw <= pyaw;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(rtype, px, py, pyaw);
    sent++;
  endtask

  task automatic push_pose(logic [31:0] px, logic [31:0] py, logic [15:0] pyaw);
    send_request(REQ_PUSH, px, py, pyaw);
  endtask

  task automatic capture();
    send_request(REQ_CAPTURE, $urandom, $urandom, 16'($urandom));
  endtask

  // Wait for drain, then write the window register
  task automatic write_window(logic [5:0] w);
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.data <= w;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    board.set_window(w);
  endtask

  function automatic logic [15:0] rand_yaw();
    case ($urandom_range(0, 5))
      0: return 16'sd16384 + 16'($urandom_range(0, 2)) - 16'd1;
      1: return -16'sd16384 + 16'($urandom_range(0, 2)) - 16'd1;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [5:0] w;
    int burst;
    calm = 0;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: capture with no pose, extremes, opposite headings
    capture();
    push_pose(32'h7fffffff, 32'h80000000, 16'h7fff);
    capture();
    push_pose(32'h7fffffff, 32'h80000000, 16'h8000);
    capture();
    push_pose(32'h80000000, 32'h7fffffff, 16'h4000);
    push_pose(32'h80000000, 32'h7fffffff, 16'hc000);
    push_pose(32'hffffffff, 32'h00000001, 16'h4001);
    push_pose(32'h00000000, 32'h00000000, 16'hbfff);
    capture();
    // Opposing yaws pushed after a window of two; the fill stays above it
    write_window(6'd2);
    push_pose(32'd5, -32'sd5, 16'h0000);
    push_pose(-32'sd2, 32'd3, 16'h8000);
    capture();
    // Window zero acts as one; shrinking keeps the fill
    write_window(6'd0);
    push_pose(32'h12345678, 32'h9abcdef0, 16'h1234);
    capture();
    write_window(6'd63);
    for (int i = 0; i < 6; i++) push_pose(rand_coord(), rand_coord(), rand_yaw());
    capture();

    // Random phases with different windows
    while (sent < 650) begin
      case ($urandom_range(0, 5))
        0: w = 6'd1;
        1: w = 6'd32;
        2: w = 6'd0;
        3: w = 6'($urandom_range(33, 63));
        default: w = 6'($urandom_range(1, 32));
      endcase
      write_window(w);
      for (int p = 0; p < 8; p++) begin
        burst = $urandom_range(0, 6);
        for (int i = 0; i < burst; i++)
          push_pose(rand_coord(), rand_coord(), rand_yaw());
        capture();
      end
      if (sent > 560) calm = 1;
    end

    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    $display("Sent %0d requests: %0d pushes, %0d captures, windows 0 to 63.",
             sent, board.pushes, board.captures);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== pose_window_circular_mean_unit.f =====
hdl/pwcm_pkg.sv
hdl/pwcm_if.sv
hdl/pwcm_cordic.sv
hdl/pose_window_circular_mean_unit.sv
tb/pose_window_scoreboard.sv
tb/testbench.sv
